FILE: rtl/imu_complementary_attitude_top_assert.svh
// Assertion macros for the attitude estimator checker.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef IMU_COMPLEMENTARY_ATTITUDE_TOP_ASSERT_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ica checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define ICA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ica checker: next-cycle property failed");

`endif

FILE: rtl/ica_pkg.sv
package ica_pkg;

  // Angle state carries STATE_FRAC fraction bits of a degree.
  localparam int STATE_FRAC  = 16;
  localparam int OUT_FRAC    = 7;
  localparam int TABLE_FRAC  = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN    = 24;
  localparam int ATAN_IW     = 5;

  localparam int ST_W   = STATE_FRAC + 9;   // stored angle, +-180 deg
  localparam int Q_W    = STATE_FRAC + 10;  // gyro step magnitude
  localparam int STEP_W = Q_W + 1;
  localparam int ANG_W  = STEP_W + 1;       // working angle
  localparam int ACC_W  = STATE_FRAC + 10;  // accel angle in state units
  localparam int XY_W   = 27;
  localparam int Z_W    = 30;
  localparam int ROOT_W = 24;
  localparam int NUM_W  = 37 + STATE_FRAC;

  localparam logic [27:0] RATE_DEN  = 28'd262400000;
  localparam logic [27:0] RATE_HALF = 28'd131200000;

  localparam logic signed [ANG_W-1:0] HALF_TURN =
    ANG_W'(180 * (1 << STATE_FRAC));
  localparam logic signed [ANG_W-1:0] FULL_TURN =
    ANG_W'(360 * (1 << STATE_FRAC));
  localparam logic signed [ANG_W-1:0] QUARTER_TURN =
    ANG_W'(90 * (1 << STATE_FRAC));
  localparam logic signed [Z_W-1:0] CORDIC_OFF =
    Z_W'(180 * (1 << TABLE_FRAC));

  // atan(2^-i) in 2^-20 degree.
  localparam logic [26:0] ATAN_TAB [0:ATAN_LEN-1] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
    27'd1876857,  27'd938658,   27'd469357,   27'd234682,  27'd117342,
    27'd58671,    27'd29335,    27'd14668,    27'd7334,    27'd3667,
    27'd1833,     27'd917,      27'd458,      27'd229,     27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

  typedef enum logic [2:0] {
    CFG_BIAS_X = 3'd0,
    CFG_BIAS_Y = 3'd1,
    CFG_BIAS_Z = 3'd2,
    CFG_STEP   = 3'd3,
    CFG_ALPHA  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_CHK, ST_SQRT, ST_CP_GO, ST_CP, ST_CR_GO, ST_CR,
    ST_GWAIT, ST_PREP, ST_BLEND, ST_WRAP, ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    G_IDLE, G_MUL, G_SEED, G_DIV
  } gyro_state_t;

  // Start and finish strobes of one iterative unit.
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

FILE: rtl/ica_isqrt.sv
// Digit-serial integer square root: two radicand bits enter per cycle.
module ica_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [30:0]                   sum_sq,
  output logic                          done,
  output logic [ica_pkg::ROOT_W-1:0]    root
);

  logic [47:0]                 sh_r;
  logic [25:0]                 rem_r;
  logic [ica_pkg::ROOT_W-1:0]  root_r;
  logic [4:0]                  cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [27:0] rem_sh;
  logic [27:0] trial;
  logic        ge;
  logic [27:0] rem_nxt;

  assign rem_sh  = {rem_r, sh_r[47:46]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_nxt = ge ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'(ica_pkg::ROOT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r   <= {1'b0, sum_sq, 16'b0};
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      sh_r   <= {sh_r[45:0], 2'b00};
      rem_r  <= rem_nxt[25:0];
      root_r <= {root_r[ica_pkg::ROOT_W-2:0], ge};
      cnt_r  <= cnt_r + 5'd1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/ica_cordic.sv
// Vectoring CORDIC for atan2, one micro-rotation per cycle.
module ica_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [24:0]                 y_in,
  input  logic signed [24:0]                 x_in,
  output logic                               done,
  output logic signed [ica_pkg::ACC_W-1:0]   angle
);

  localparam int RS = ica_pkg::TABLE_FRAC - ica_pkg::STATE_FRAC;

  logic signed [ica_pkg::XY_W-1:0]  x_r, y_r;
  logic signed [ica_pkg::Z_W-1:0]   z_r;
  logic [ica_pkg::ATAN_IW-1:0]      i_r;
  logic                             busy_r;
  logic                             done_r;
  logic signed [ica_pkg::ACC_W-1:0] ang_r;

  logic signed [ica_pkg::XY_W-1:0] x_ext, y_ext, dx, dy, x_nxt, y_nxt;
  logic signed [ica_pkg::Z_W-1:0]  tab, z_nxt, z_rnd;
  logic                            last;

  assign x_ext = ica_pkg::XY_W'(x_in);
  assign y_ext = ica_pkg::XY_W'(y_in);
  assign dx    = x_r >>> i_r;
  assign dy    = y_r >>> i_r;
  assign tab   = $signed({3'b000, ica_pkg::ATAN_TAB[i_r]});
  assign last  = i_r == ica_pkg::ATAN_IW'(ica_pkg::CORDIC_STEPS - 1);

  always_comb begin
    if (!y_r[ica_pkg::XY_W-1]) begin
      x_nxt = x_r + dy;
      y_nxt = y_r - dx;
      z_nxt = z_r + tab;
    end else begin
      x_nxt = x_r - dy;
      y_nxt = y_r + dx;
      z_nxt = z_r - tab;
    end
    z_rnd = (z_nxt + ica_pkg::Z_W'(1 << (RS - 1))) >>> RS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !(x_in == '0 && y_in == '0);
        done_r <= x_in == '0 && y_in == '0;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i_r   <= '0;
      ang_r <= '0;
      if (x_in < 0) begin
        x_r <= -x_ext;
        y_r <= -y_ext;
        z_r <= (y_in >= 0) ? ica_pkg::CORDIC_OFF : -ica_pkg::CORDIC_OFF;
      end else begin
        x_r <= x_ext;
        y_r <= y_ext;
        z_r <= '0;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      i_r <= i_r + 1'b1;
      if (last) begin
        ang_r <= z_rnd[ica_pkg::ACC_W-1:0];
      end
    end
  end

  assign done  = done_r;
  assign angle = ang_r;

endmodule

FILE: rtl/ica_gyro_div.sv
// Gyro angle steps for three axes, one restoring-division bit per cycle.
module ica_gyro_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [20:0]                 rate_x,
  input  logic signed [20:0]                 rate_y,
  input  logic signed [20:0]                 rate_z,
  input  logic [15:0]                        step_time,
  output logic                               done,
  output logic signed [ica_pkg::STEP_W-1:0]  step_x,
  output logic signed [ica_pkg::STEP_W-1:0]  step_y,
  output logic signed [ica_pkg::STEP_W-1:0]  step_z
);

  localparam int QW = ica_pkg::Q_W;
  localparam int NW = ica_pkg::NUM_W;

  ica_pkg::gyro_state_t state_r, state_nxt;

  logic [1:0]                        axis_r;
  logic                              neg_r;
  logic [35:0]                       prod_r;
  logic [27:0]                       rem_r;
  logic [QW-1:0]                     nsh_r;
  logic [QW-1:0]                     q_r;
  logic [4:0]                        cnt_r;
  logic                              done_r;
  logic signed [ica_pkg::STEP_W-1:0] sx_r, sy_r, sz_r;

  logic signed [20:0]                rate_sel;
  logic [20:0]                       mag;
  logic [NW-1:0]                     num;
  logic [28:0]                       trial;
  logic                              ge;
  logic [28:0]                       rem_nxt;
  logic [QW-1:0]                     q_fin;
  logic signed [ica_pkg::STEP_W-1:0] q_signed;
  logic                              div_last;

  always_comb begin
    case (axis_r)
      2'd0:    rate_sel = rate_x;
      2'd1:    rate_sel = rate_y;
      default: rate_sel = rate_z;
    endcase
  end

  assign mag      = rate_sel[20] ? 21'(-rate_sel) : 21'(rate_sel);
  assign num      = {1'b0, prod_r, {ica_pkg::STATE_FRAC{1'b0}}} + NW'(ica_pkg::RATE_HALF);
  assign trial    = {rem_r, nsh_r[QW-1]};
  assign ge       = trial >= {1'b0, ica_pkg::RATE_DEN};
  assign rem_nxt  = ge ? trial - {1'b0, ica_pkg::RATE_DEN} : trial;
  assign q_fin    = {q_r[QW-2:0], ge};
  assign q_signed = neg_r ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
  assign div_last = cnt_r == 5'(QW - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ica_pkg::G_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ica_pkg::G_IDLE: if (start) state_nxt = ica_pkg::G_MUL;
      ica_pkg::G_MUL:  state_nxt = ica_pkg::G_SEED;
      ica_pkg::G_SEED: state_nxt = ica_pkg::G_DIV;
      ica_pkg::G_DIV: begin
        if (div_last) begin
          state_nxt = (axis_r == 2'd2) ? ica_pkg::G_IDLE : ica_pkg::G_MUL;
        end
      end
      default: state_nxt = ica_pkg::G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      axis_r <= '0;
    end else begin
      if (state_r == ica_pkg::G_IDLE && start) begin
        done_r <= 1'b0;
        axis_r <= '0;
      end else if (state_r == ica_pkg::G_DIV && div_last) begin
        if (axis_r == 2'd2) begin
          done_r <= 1'b1;
        end else begin
          axis_r <= axis_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ica_pkg::G_MUL: begin
        prod_r <= 36'(mag[19:0] * step_time);
        neg_r  <= rate_sel[20];
      end
      ica_pkg::G_SEED: begin
        rem_r <= {1'b0, num[NW-1:QW]};
        nsh_r <= num[QW-1:0];
        q_r   <= '0;
        cnt_r <= '0;
      end
      ica_pkg::G_DIV: begin
        rem_r <= rem_nxt[27:0];
        nsh_r <= {nsh_r[QW-2:0], 1'b0};
        q_r   <= q_fin;
        cnt_r <= cnt_r + 5'd1;
        if (div_last) begin
          case (axis_r)
            2'd0:    sx_r <= q_signed;
            2'd1:    sy_r <= q_signed;
            default: sz_r <= q_signed;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign done   = done_r;
  assign step_x = sx_r;
  assign step_y = sy_r;
  assign step_z = sz_r;

endmodule

FILE: rtl/imu_complementary_attitude_top.sv
// The gyro step divider (26 quotient bits per axis, one per cycle, three axes) dominates
// the time from an accepted word to its result in the output register, while the
// accel path (squares, root, two CORDIC runs) runs beside it.
// One sample at a time: the next word is accepted once the result is loaded.
// Reset: synchronous active-low rst_n restores register defaults, zeroes the angles
// and arms the first-sample load.
module imu_complementary_attitude_top (
  input  logic        clk,
  input  logic        rst_n,
  // accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw, rate_z_raw
  input  logic [95:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pitch_angle[14:0], roll_angle[30:15], yaw_angle[46:31], zero pad
  output logic [47:0] out_tdata,
  // updated
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [19:0] cfg_wdata
);

  localparam int AW  = ica_pkg::ANG_W;
  localparam int SW  = ica_pkg::ST_W;
  localparam int OSH = ica_pkg::STATE_FRAC - ica_pkg::OUT_FRAC;

  // Stored angle rounded half up to 1/128 degree.
  function automatic logic [15:0] to_out(input logic signed [SW-1:0] st);
    logic signed [SW:0] t;
    t = (SW+1)'(st) + (SW+1)'(1 << (OSH - 1));
    return 16'(t >>> OSH);
  endfunction

  // Blend sum rounded half up and brought back to state units.
  function automatic logic signed [AW-1:0] bl_round(input logic signed [46:0] s);
    logic signed [46:0] t;
    t = s + 47'sd32768;
    return AW'(t >>> 16);
  endfunction

  ica_pkg::top_state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [19:0] bias_x_r, bias_y_r, bias_z_r;
  logic [15:0]        step_time_r;
  logic [15:0]        alpha_r;

  // Sample in the body frame.
  logic signed [15:0] bx_r, by_r, bz_r;
  logic signed [20:0] wx_r, wy_r, wz_r;
  logic               gyro_go_r;

  logic [30:0] s_r;
  logic [30:0] bxsq_r;
  logic [2:0]  cnt_r;
  logic        upd_r;
  logic        first_r;

  logic signed [ica_pkg::ACC_W-1:0] accp_r, accr_r;
  logic signed [AW-1:0]             gp_r, gr_r;
  logic signed [AW-1:0]             pitch_w_r, roll_w_r, yaw_w_r;
  logic signed [45:0]               prod_r;
  logic signed [45:0]               sum_r;

  logic signed [SW-1:0] pitch_st_r, roll_st_r, yaw_st_r;

  logic [47:0] out_data_r;
  logic        out_user_r;
  logic        out_valid_r;

  // Input decode.
  logic               accept;
  logic signed [15:0] ax_in, ay_in, az_in, rx_in, ry_in, rz_in;
  logic signed [15:0] by_in;
  logic signed [20:0] cx_in, cy_in, cz_in;

  assign ax_in = in_tdata[15:0];
  assign ay_in = in_tdata[31:16];
  assign az_in = in_tdata[47:32];
  assign rx_in = in_tdata[63:48];
  assign ry_in = in_tdata[79:64];
  assign rz_in = in_tdata[95:80];

  // Body y is the negated chip z; the one value with no positive twin saturates.
  assign by_in = (az_in == 16'sh8000) ? 16'sh7fff : -az_in;
  assign cx_in = $signed({rx_in[15], rx_in, 4'b0}) - $signed({bias_x_r[19], bias_x_r});
  assign cy_in = $signed({ry_in[15], ry_in, 4'b0}) - $signed({bias_y_r[19], bias_y_r});
  assign cz_in = $signed({rz_in[15], rz_in, 4'b0}) - $signed({bias_z_r[19], bias_z_r});

  assign in_tready = state_r == ica_pkg::ST_IDLE;
  assign accept    = in_tvalid && in_tready;

  // Squares for the norm test and the root radicand, one per cycle.
  logic signed [15:0] sq_op;
  logic signed [31:0] sq_full;
  logic [31:0]        norm;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_op = by_r;
      2'd1:    sq_op = bz_r;
      default: sq_op = bx_r;
    endcase
  end

  assign sq_full = sq_op * sq_op;
  assign norm    = {1'b0, s_r} + {1'b0, bxsq_r};

  // Iterative units.
  logic                             sqrt_start, sqrt_done;
  logic                             cor_start, cor_done;
  logic                             gyro_done;
  logic [ica_pkg::ROOT_W-1:0]       root;
  logic                             cor_roll;
  logic signed [24:0]               cor_y, cor_x;
  logic signed [ica_pkg::ACC_W-1:0] cor_angle;
  logic signed [ica_pkg::STEP_W-1:0] step_x, step_y, step_z;

  ica_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sqrt_start),
    .sum_sq (s_r),
    .done   (sqrt_done),
    .root   (root)
  );

  // Pitch uses atan2(-bx, |(by, bz)|), roll uses atan2(by, bz), both scaled by 256.
  assign cor_y = cor_roll ? $signed({by_r[15], by_r, 8'b0})
                          : -$signed({bx_r[15], bx_r, 8'b0});
  assign cor_x = cor_roll ? $signed({bz_r[15], bz_r, 8'b0})
                          : $signed({1'b0, root});

  ica_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .angle (cor_angle)
  );

  ica_gyro_div u_gyro_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (gyro_go_r),
    .rate_x    (wx_r),
    .rate_y    (wy_r),
    .rate_z    (wz_r),
    .step_time (step_time_r),
    .done      (gyro_done),
    .step_x    (step_x),
    .step_y    (step_y),
    .step_z    (step_z)
  );

  // Blend multiplier, shared by four products in turn: alpha on the gyro path and
  // (1 - alpha) on the accel path, pitch first and roll second.
  logic signed [17:0] alpha_s, beta_s, ma;
  logic signed [AW-1:0] mb;
  logic signed [45:0] bl_prod;

  assign alpha_s = $signed({2'b00, alpha_r});
  assign beta_s  = 18'sd65536 - alpha_s;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin
        ma = alpha_s;
        mb = gp_r;
      end
      2'd1: begin
        ma = beta_s;
        mb = AW'(accp_r);
      end
      2'd2: begin
        ma = alpha_s;
        mb = gr_r;
      end
      default: begin
        ma = beta_s;
        mb = AW'(accr_r);
      end
    endcase
  end

  assign bl_prod = ma * mb;

  // Wrap one turn per cycle until roll and yaw sit in [-180, 180]; clamp pitch.
  logic roll_hi, roll_lo, yaw_hi, yaw_lo, wrap_done;
  logic signed [AW-1:0] pitch_cl;

  assign roll_hi   = roll_w_r > ica_pkg::HALF_TURN;
  assign roll_lo   = roll_w_r < -ica_pkg::HALF_TURN;
  assign yaw_hi    = yaw_w_r > ica_pkg::HALF_TURN;
  assign yaw_lo    = yaw_w_r < -ica_pkg::HALF_TURN;
  assign wrap_done = !(roll_hi || roll_lo || yaw_hi || yaw_lo);

  always_comb begin
    if (pitch_w_r > ica_pkg::QUARTER_TURN) begin
      pitch_cl = ica_pkg::QUARTER_TURN;
    end else if (pitch_w_r < -ica_pkg::QUARTER_TURN) begin
      pitch_cl = -ica_pkg::QUARTER_TURN;
    end else begin
      pitch_cl = pitch_w_r;
    end
  end

  // Sequencer.
  logic out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ica_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    sqrt_start = 1'b0;
    cor_start  = 1'b0;
    cor_roll   = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ica_pkg::ST_IDLE: begin
        if (accept) state_nxt = ica_pkg::ST_SQ;
      end
      ica_pkg::ST_SQ: begin
        if (cnt_r == 3'd2) state_nxt = ica_pkg::ST_CHK;
      end
      ica_pkg::ST_CHK: begin
        // An accel norm below 0.001 g leaves the angles alone.
        if (norm > 32'd4) begin
          sqrt_start = 1'b1;
          state_nxt  = ica_pkg::ST_SQRT;
        end else begin
          state_nxt = ica_pkg::ST_GWAIT;
        end
      end
      ica_pkg::ST_SQRT: begin
        if (sqrt_done) state_nxt = ica_pkg::ST_CP_GO;
      end
      ica_pkg::ST_CP_GO: begin
        cor_start = 1'b1;
        state_nxt = ica_pkg::ST_CP;
      end
      ica_pkg::ST_CP: begin
        if (cor_done) state_nxt = ica_pkg::ST_CR_GO;
      end
      ica_pkg::ST_CR_GO: begin
        cor_roll  = 1'b1;
        cor_start = 1'b1;
        state_nxt = ica_pkg::ST_CR;
      end
      ica_pkg::ST_CR: begin
        cor_roll = 1'b1;
        if (cor_done) state_nxt = ica_pkg::ST_GWAIT;
      end
      ica_pkg::ST_GWAIT: begin
        if (gyro_done) begin
          if (!upd_r) begin
            state_nxt = ica_pkg::ST_OUT;
          end else if (first_r) begin
            state_nxt = ica_pkg::ST_WRAP;
          end else begin
            state_nxt = ica_pkg::ST_PREP;
          end
        end
      end
      ica_pkg::ST_PREP: state_nxt = ica_pkg::ST_BLEND;
      ica_pkg::ST_BLEND: begin
        if (cnt_r == 3'd4) state_nxt = ica_pkg::ST_WRAP;
      end
      ica_pkg::ST_WRAP: begin
        if (wrap_done) state_nxt = ica_pkg::ST_OUT;
      end
      ica_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ica_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ica_pkg::ST_IDLE;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_x_r    <= '0;
      bias_y_r    <= '0;
      bias_z_r    <= '0;
      step_time_r <= 16'd5000;
      alpha_r     <= 16'd64225;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ica_pkg::CFG_BIAS_X: bias_x_r    <= cfg_wdata;
        ica_pkg::CFG_BIAS_Y: bias_y_r    <= cfg_wdata;
        ica_pkg::CFG_BIAS_Z: bias_z_r    <= cfg_wdata;
        ica_pkg::CFG_STEP:   step_time_r <= cfg_wdata[15:0];
        ica_pkg::CFG_ALPHA:  alpha_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Control flags and the architectural angle state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_go_r   <= 1'b0;
      upd_r       <= 1'b0;
      first_r     <= 1'b1;
      pitch_st_r  <= '0;
      roll_st_r   <= '0;
      yaw_st_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gyro_go_r <= accept;
      if (state_r == ica_pkg::ST_CHK) begin
        upd_r <= norm > 32'd4;
      end
      if (state_r == ica_pkg::ST_WRAP && wrap_done) begin
        pitch_st_r <= pitch_cl[SW-1:0];
        roll_st_r  <= roll_w_r[SW-1:0];
        yaw_st_r   <= yaw_w_r[SW-1:0];
        first_r    <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      bx_r <= ax_in;
      by_r <= by_in;
      bz_r <= ay_in;
      wx_r <= cx_in;
      wy_r <= -cz_in;
      wz_r <= cy_in;
      cnt_r <= '0;
    end
    case (state_r)
      ica_pkg::ST_SQ: begin
        cnt_r <= cnt_r + 3'd1;
        case (cnt_r[1:0])
          2'd0:    s_r    <= sq_full[30:0];
          2'd1:    s_r    <= s_r + sq_full[30:0];
          default: bxsq_r <= sq_full[30:0];
        endcase
      end
      ica_pkg::ST_CP: begin
        if (cor_done) accp_r <= cor_angle;
      end
      ica_pkg::ST_CR: begin
        if (cor_done) accr_r <= cor_angle;
      end
      ica_pkg::ST_GWAIT: begin
        // First valid sample: load straight from the accelerometer.
        pitch_w_r <= AW'(accp_r);
        roll_w_r  <= AW'(accr_r);
        yaw_w_r   <= '0;
      end
      ica_pkg::ST_PREP: begin
        gp_r    <= AW'(pitch_st_r) + AW'(step_x);
        gr_r    <= AW'(roll_st_r) + AW'(step_y);
        yaw_w_r <= AW'(yaw_st_r) + AW'(step_z);
        cnt_r   <= '0;
      end
      ica_pkg::ST_BLEND: begin
        cnt_r  <= cnt_r + 3'd1;
        prod_r <= bl_prod;
        case (cnt_r)
          3'd1:    sum_r     <= prod_r;
          3'd2:    pitch_w_r <= bl_round(47'(sum_r) + 47'(prod_r));
          3'd3:    sum_r     <= prod_r;
          3'd4:    roll_w_r  <= bl_round(47'(sum_r) + 47'(prod_r));
          default: ;
        endcase
      end
      ica_pkg::ST_WRAP: begin
        if (roll_hi) begin
          roll_w_r <= roll_w_r - ica_pkg::FULL_TURN;
        end else if (roll_lo) begin
          roll_w_r <= roll_w_r + ica_pkg::FULL_TURN;
        end
        if (yaw_hi) begin
          yaw_w_r <= yaw_w_r - ica_pkg::FULL_TURN;
        end else if (yaw_lo) begin
          yaw_w_r <= yaw_w_r + ica_pkg::FULL_TURN;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {1'b0, to_out(yaw_st_r), to_out(roll_st_r), 15'(to_out(pitch_st_r))};
      out_user_r <= upd_r;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

endmodule

FILE: rtl/ica_checker.sv
// Port-level checks for the attitude estimator.
module ica_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

`include "imu_complementary_attitude_top_assert.svh"

  `ICA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `ICA_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))
  // One sample in flight: the block is busy right after it takes a word.
  `ICA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `ICA_ASSERT_SAME(a_pitch_range, out_tvalid, ($signed(out_tdata[14:0]) <= 15'sd11520) && ($signed(out_tdata[14:0]) >= -15'sd11520))
  `ICA_ASSERT_SAME(a_roll_range, out_tvalid, ($signed(out_tdata[30:15]) <= 16'sd23040) && ($signed(out_tdata[30:15]) >= -16'sd23040))

endmodule

bind imu_complementary_attitude_top ica_checker u_ica_checker (.*);

FILE: tb/sv/imu_complementary_attitude_top_test.sv
module imu_complementary_attitude_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected output word: the three angles and the update flag.
  typedef struct {
    logic [14:0] pitch;
    logic [15:0] roll;
    logic [15:0] yaw;
    logic        updated;
  } attitude_t;

  // The scoreboard holds its own copy of the filter state and register file,
  // predicts the attitude for each accepted sample and checks the output words
  // against those predictions in order.
  class attitude_scoreboard;
    longint bias_x, bias_y, bias_z;
    longint step_us, alpha;
    longint pitch_st, roll_st, yaw_st;
    bit     awaiting_first;
    attitude_t pending_q[$];
    int     mismatches;
    int     results_seen;
    int     updates_seen;

    function void reset_state();
      bias_x = 0; bias_y = 0; bias_z = 0;
      step_us = 5000; alpha = 64225;
      pitch_st = 0; roll_st = 0; yaw_st = 0;
      awaiting_first = 1;
    endfunction

    function void write_reg(ica_pkg::cfg_reg_t idx, logic [19:0] val);
      case (idx)
        ica_pkg::CFG_BIAS_X: bias_x = longint'($signed(val));
        ica_pkg::CFG_BIAS_Y: bias_y = longint'($signed(val));
        ica_pkg::CFG_BIAS_Z: bias_z = longint'($signed(val));
        ica_pkg::CFG_STEP:   step_us = longint'(val[15:0]);
        ica_pkg::CFG_ALPHA:  alpha = longint'(val[15:0]);
        default: ;
      endcase
    endfunction

    // Arithmetic shift right that floors, independent of the simulator.
    function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    function longint round_half_up(longint v, int s);
      if (s == 0) return v;
      return floor_shift(v + (longint'(1) <<< (s - 1)), s);
    endfunction

    function longint int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return longint'(res);
    endfunction

    // Vectoring CORDIC, result in 2^-20 degree.
    function longint angle_of(longint y, longint x);
      longint z, off, dx, dy;
      z = 0;
      off = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        off = (y >= 0) ? (longint'(180) <<< ica_pkg::TABLE_FRAC)
                       : -(longint'(180) <<< ica_pkg::TABLE_FRAC);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < ica_pkg::CORDIC_STEPS && i < ica_pkg::ATAN_LEN; i++) begin
        dx = floor_shift(x, i);
        dy = floor_shift(y, i);
        if (y >= 0) begin
          x += dy; y -= dx; z += longint'(ica_pkg::ATAN_TAB[i]);
        end else begin
          x -= dy; y += dx; z -= longint'(ica_pkg::ATAN_TAB[i]);
        end
      end
      return z + off;
    endfunction

    // Angle increment in state units, rounded to nearest, ties away from zero.
    function longint rate_increment(longint rate16);
      longint unsigned mag, q;
      mag = (rate16 < 0) ? -rate16 : rate16;
      q = (mag * longint'(step_us) * (64'd1 << ica_pkg::STATE_FRAC) + 64'd131200000)
          / 64'd262400000;
      return (rate16 < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint mix(longint gyro_ang, longint acc_ang);
      return floor_shift(alpha * gyro_ang + (65536 - alpha) * acc_ang + 32768, 16);
    endfunction

    function longint wrap_turn(longint v);
      longint h;
      h = longint'(180) <<< ica_pkg::STATE_FRAC;
      while (v > h) v -= 2 * h;
      while (v < -h) v += 2 * h;
      return v;
    endfunction

    function void note_sample(logic [95:0] word);
      longint ax, ay, az, cx, cy, cz, bx, by, bz, wx, wy, wz, h90, r, accp, accr;
      attitude_t e;
      ax = longint'($signed(word[15:0]));
      ay = longint'($signed(word[31:16]));
      az = longint'($signed(word[47:32]));
      cx = longint'($signed(word[63:48])) * 16 - bias_x;
      cy = longint'($signed(word[79:64])) * 16 - bias_y;
      cz = longint'($signed(word[95:80])) * 16 - bias_z;
      // Body y is the negated chip z axis, saturated at the positive end.
      bx = ax;
      by = (az == -32768) ? 32767 : -az;
      bz = ay;
      wx = cx; wy = -cz; wz = cy;
      h90 = longint'(90) <<< ica_pkg::STATE_FRAC;
      e.updated = 0;
      // A tiny accel norm leaves the angles alone.
      if (bx * bx + by * by + bz * bz > 4) begin
        r = int_sqrt(longint'((by * by + bz * bz)) << 16);
        accp = round_half_up(angle_of(-bx * 256, r),
                             ica_pkg::TABLE_FRAC - ica_pkg::STATE_FRAC);
        accr = round_half_up(angle_of(by * 256, bz * 256),
                             ica_pkg::TABLE_FRAC - ica_pkg::STATE_FRAC);
        if (awaiting_first) begin
          pitch_st = accp;
          roll_st = accr;
          yaw_st = 0;
          awaiting_first = 0;
        end else begin
          yaw_st += rate_increment(wz);
          pitch_st = mix(pitch_st + rate_increment(wx), accp);
          roll_st = mix(roll_st + rate_increment(wy), accr);
        end
        yaw_st = wrap_turn(yaw_st);
        roll_st = wrap_turn(roll_st);
        if (pitch_st > h90) pitch_st = h90;
        else if (pitch_st < -h90) pitch_st = -h90;
        e.updated = 1;
      end
      e.pitch = 15'(round_half_up(pitch_st, ica_pkg::STATE_FRAC - ica_pkg::OUT_FRAC));
      e.roll = 16'(round_half_up(roll_st, ica_pkg::STATE_FRAC - ica_pkg::OUT_FRAC));
      e.yaw = 16'(round_half_up(yaw_st, ica_pkg::STATE_FRAC - ica_pkg::OUT_FRAC));
      pending_q.push_back(e);
    endfunction

    function void check_result(logic [47:0] data, logic upd);
      attitude_t e;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output word %h updated=%b", data, upd);
        return;
      end
      e = pending_q.pop_front();
      if (upd) updates_seen++;
      if (data[14:0] !== e.pitch || data[30:15] !== e.roll || data[46:31] !== e.yaw ||
          data[47] !== 1'b0 || upd !== e.updated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word %0d pitch %0d/%0d roll %0d/%0d yaw %0d/%0d upd %b/%b (exp/act)",
                   results_seen, $signed(e.pitch), $signed(data[14:0]),
                   $signed(e.roll), $signed(data[30:15]),
                   $signed(e.yaw), $signed(data[46:31]), e.updated, upd);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [95:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [19:0] cfg_wdata = '0;

  attitude_scoreboard attitude_sb = new();

  // Idling is switched off for the final stretch of the run.
  bit   idle_enabled = 1'b1;
  int   samples_sent = 0;

  always #5 clk = ~clk;

  imu_complementary_attitude_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Output side: the receiver stalls in random bursts while idling is on.
  // Words are checked at the edge where the handshake completes.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 19);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid && out_tready) attitude_sb.check_result(out_tdata, out_tuser);
    end
  end

  // One register write, after which the write port goes quiet before the task returns.
  task automatic write_reg(ica_pkg::cfg_reg_t idx, logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    attitude_sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Sends one sample word; the sender may first idle for a random burst.
  // Valid stays high after the handshake so that back-to-back calls keep it up.
  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    int gap;
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {gz, gy, gx, az, ay, ax};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    attitude_sb.note_sample({gz, gy, gx, az, ay, ax});
    samples_sent++;
  endtask

  // Waits until every expected word has arrived, then lets the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (attitude_sb.pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [15:0] any_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 4)) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  // A random accel vector, each axis in [-2048, 2048], with gyro rates in [-1000, 1000].
  task automatic send_realistic();
    int ax, ay, az;
    ax = int'($urandom_range(0, 4096)) - 2048;
    ay = int'($urandom_range(0, 4096)) - 2048;
    az = int'($urandom_range(0, 4096)) - 2048;
    send_sample(16'(ax), 16'(ay), 16'(az),
                16'(int'($urandom_range(0, 2000)) - 1000),
                16'(int'($urandom_range(0, 2000)) - 1000),
                16'(int'($urandom_range(0, 2000)) - 1000));
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) send_realistic();
      else if ($urandom_range(0, 9) == 0)
        // Accel inside the tiny-norm region, so the update is skipped.
        send_sample(16'(int'($urandom_range(0, 2)) - 1), 16'(int'($urandom_range(0, 2)) - 1),
                    16'(int'($urandom_range(0, 2)) - 1), any_word(), any_word(), any_word());
      else send_sample(any_word(), any_word(), any_word(), any_word(), any_word(), any_word());
    end
  endtask

  initial begin
    attitude_sb.reset_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the reset register values. The first sample has
    // a tiny norm so the first-sample load is deferred to the next one.
    send_sample(16'd1, 16'd1, 16'd0, 16'h7fff, 16'h8000, 16'd5);
    send_sample(16'd0, 16'd2048, 16'd0, 16'd100, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'd0, 16'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h7fff, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'hf800, 16'd0, 16'h7fff, 16'd0, 16'h7fff);
    send_sample(16'd0, 16'hf800, 16'd1, 16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'hf800, 16'hffff, 16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd0);
    send_sample(16'd2, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    // The sender holds off until everything has come back.
    drain();

    // Extreme settings: largest step and full gyro weight let yaw wrap several
    // times over; negative extreme biases.
    write_reg(ica_pkg::CFG_BIAS_X, 20'h80000);
    write_reg(ica_pkg::CFG_BIAS_Y, 20'h80000);
    write_reg(ica_pkg::CFG_BIAS_Z, 20'h80000);
    write_reg(ica_pkg::CFG_STEP, 20'd65535);
    write_reg(ica_pkg::CFG_ALPHA, 20'd65535);
    for (int i = 0; i < 6; i++)
      send_sample(16'd0, 16'd2048, 16'd0, 16'h7fff, 16'h8000, 16'h7fff);
    random_phase(200);
    drain();

    // Zero step time and pure accel weighting, largest positive biases.
    write_reg(ica_pkg::CFG_BIAS_X, 20'h7ffff);
    write_reg(ica_pkg::CFG_BIAS_Y, 20'h7ffff);
    write_reg(ica_pkg::CFG_BIAS_Z, 20'h7ffff);
    write_reg(ica_pkg::CFG_STEP, 20'd0);
    write_reg(ica_pkg::CFG_ALPHA, 20'd0);
    random_phase(200);
    drain();

    write_reg(ica_pkg::CFG_STEP, 20'd1);
    write_reg(ica_pkg::CFG_ALPHA, 20'd32768);
    random_phase(200);
    drain();

    // Several random settings.
    for (int p = 0; p < 4; p++) begin
      write_reg(ica_pkg::CFG_BIAS_X, 20'($urandom));
      write_reg(ica_pkg::CFG_BIAS_Y, 20'($urandom));
      write_reg(ica_pkg::CFG_BIAS_Z, 20'($urandom));
      write_reg(ica_pkg::CFG_STEP, 20'($urandom_range(1, 65535)));
      write_reg(ica_pkg::CFG_ALPHA, 20'($urandom_range(0, 65535)));
      random_phase(200);
      drain();
    end

    // Last stretch at full rate with no idling on either side.
    idle_enabled = 1'b0;
    random_phase(187);
    drain();

    $display("Covered %0d samples over 8 register settings, %0d output words, %0d updates.",
             samples_sent, attitude_sb.results_seen, attitude_sb.updates_seen);
    $display("Mismatches: %0d, words still expected: %0d.",
             attitude_sb.mismatches, attitude_sb.pending_q.size());
    if (attitude_sb.mismatches == 0 && attitude_sb.pending_q.size() == 0)
      $display("PASS imu_complementary_attitude_top");
    else
      $display("FAIL imu_complementary_attitude_top");
    $finish;
  end

  // About 1600 samples plus stalls stay far below this bound.
  initial begin
    #20ms;
    $display("FAIL imu_complementary_attitude_top");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ica_pkg.sv
rtl/ica_isqrt.sv
rtl/ica_cordic.sv
rtl/ica_gyro_div.sv
rtl/imu_complementary_attitude_top.sv
rtl/ica_checker.sv
tb/sv/imu_complementary_attitude_top_test.sv
